// ===== sv/mvmb_pkg.sv =====
// Shared types and constants for the matrix-vector multiply-accumulate-bias block.
package mvmb_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 10;

    localparam logic [CNT_W-1:0] CNT_MAX   = 11'd2047;
    localparam logic [CNT_W-1:0] COL_RESET = 11'd1024;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_BADD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        index;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
        logic                     count_error;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic act_write;
        logic capture;
        logic mul_en;
        logic acc_en;
        logic acc_bias;
        logic emit;
    } cmd_t;

endpackage

// ===== sv/mvmb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mvmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mvmb_ctrl.sv =====
// Controller state machine: sequences load, weight and bias items through the datapath.
module mvmb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    output logic                busy,
    output mvmb_pkg::cmd_t      cmd
);

    mvmb_pkg::state_t state_reg;
    mvmb_pkg::state_t state_next;
    logic             accept;

    assign busy   = (state_reg != mvmb_pkg::S_IDLE);
    assign accept = start && !busy;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvmb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvmb_pkg::S_IDLE:
            begin
                if (accept && op == mvmb_pkg::OP_WEIGHT)
                begin
                    state_next = mvmb_pkg::S_MUL;
                end
                else if (accept && op == mvmb_pkg::OP_BIAS)
                begin
                    state_next = mvmb_pkg::S_BADD;
                end
            end
            mvmb_pkg::S_MUL:  state_next = mvmb_pkg::S_ACC;
            mvmb_pkg::S_ACC:  state_next = mvmb_pkg::S_IDLE;
            mvmb_pkg::S_BADD: state_next = mvmb_pkg::S_EMIT;
            mvmb_pkg::S_EMIT: state_next = mvmb_pkg::S_IDLE;
            default:          state_next = mvmb_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            mvmb_pkg::S_IDLE:
            begin
                cmd.act_write = accept && (op == mvmb_pkg::OP_LOAD);
                cmd.capture   = accept && (op == mvmb_pkg::OP_WEIGHT || op == mvmb_pkg::OP_BIAS);
            end
            mvmb_pkg::S_MUL:  cmd.mul_en = 1'b1;
            mvmb_pkg::S_ACC:  cmd.acc_en = 1'b1;
            mvmb_pkg::S_BADD:
            begin
                cmd.acc_en   = 1'b1;
                cmd.acc_bias = 1'b1;
            end
            mvmb_pkg::S_EMIT: cmd.emit = 1'b1;
            default:          cmd = '0;
        endcase
    end

endmodule

// ===== sv/mvmb_dp.sv =====
// Datapath: activation store, multiplier, saturating accumulator, rounding and clipping.
module mvmb_dp #(
    parameter int MAX_COLS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mvmb_pkg::cmd_t                 cmd,
    input  mvmb_pkg::item_t                item,
    input  logic                           cfg_we,
    input  logic [mvmb_pkg::CNT_W-1:0]     cfg_data,
    output logic                           done,
    output mvmb_pkg::result_t              result
);

    localparam int AW     = $clog2(MAX_COLS);
    localparam int DW     = mvmb_pkg::DATA_W;
    localparam int ACC_W  = mvmb_pkg::ACC_W;
    localparam int PW     = mvmb_pkg::PROD_W;
    localparam int FB     = mvmb_pkg::FRAC_BITS;
    localparam int CW     = mvmb_pkg::CNT_W;

    logic [CW-1:0]           column_count_reg;
    logic [CW-1:0]           counter_reg;
    logic signed [DW-1:0]    value_reg;
    logic signed [PW-1:0]    product_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    ovf_reg;
    logic                    done_reg;
    mvmb_pkg::result_t       result_reg;

    logic [31:0]             idx_ext;
    logic [31:0]             cnt_ext;
    logic                    ram_we;
    logic [DW-1:0]           ram_rdata;
    logic signed [DW-1:0]    act;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_next;
    logic                    acc_ovf;
    logic signed [ACC_W:0]   rnd_sum;
    logic                    in_range;
    mvmb_pkg::result_t       result_next;

    // Activation store addressing; writes past the store are dropped
    assign idx_ext = 32'(item.index);
    assign cnt_ext = 32'(counter_reg);
    assign ram_we  = cmd.act_write && (idx_ext < 32'(MAX_COLS));

    mvmb_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_COLS)
    ) u_act_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (item.value),
        .raddr (cnt_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Columns past the store multiply by zero
    assign act = (cnt_ext < 32'(MAX_COLS)) ? $signed(ram_rdata) : '0;

    // Saturating accumulate of product or aligned bias
    always_comb
    begin
        if (cmd.acc_bias)
        begin
            addend = ACC_W'($signed({value_reg, {FB{1'b0}}}));
        end
        else
        begin
            addend = ACC_W'(product_reg);
        end
        acc_sum = {acc_reg[ACC_W-1], acc_reg} + {addend[ACC_W-1], addend};
        acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
        if (!acc_ovf)
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        else if (acc_sum[ACC_W])
        begin
            acc_next = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            acc_next = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // Round half up to Q4.12 and clip
    always_comb
    begin
        rnd_sum  = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(1 << (FB - 1));
        in_range = (rnd_sum[ACC_W:FB+DW-1] == '0) || (rnd_sum[ACC_W:FB+DW-1] == '1);
        result_next.count_error = (counter_reg != column_count_reg);
        if (in_range)
        begin
            result_next.result_value = rnd_sum[FB+DW-1:FB];
            result_next.saturated    = ovf_reg;
        end
        else
        begin
            result_next.result_value = rnd_sum[ACC_W] ? {1'b1, {(DW-1){1'b0}}}
                                                      : {1'b0, {(DW-1){1'b1}}};
            result_next.saturated    = 1'b1;
        end
    end

    // Control state of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= mvmb_pkg::COL_RESET;
            counter_reg      <= '0;
            acc_reg          <= '0;
            ovf_reg          <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_we)
            begin
                column_count_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                counter_reg <= '0;
                acc_reg     <= '0;
                ovf_reg     <= 1'b0;
            end
            else if (cmd.acc_en)
            begin
                acc_reg <= acc_next;
                ovf_reg <= ovf_reg || acc_ovf;
                if (!cmd.acc_bias && counter_reg != mvmb_pkg::CNT_MAX)
                begin
                    counter_reg <= counter_reg + CW'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= item.value;
        end
        if (cmd.mul_en)
        begin
            product_reg <= value_reg * act;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/matrix_vector_mac_bias.sv =====
// Top level of the dense-layer matrix-vector multiply with bias.
// Load: busy stays low. Weight: busy through the multiply and accumulate states.
// Bias: busy through the bias-add and emit states; done is registered from emit, high as busy falls.
// Rate is set by the single shared multiplier/accumulator; the receiver cannot stall.
// rst_n is asynchronous, active low: clears control, counter, accumulator; column_count = 1024.
module matrix_vector_mac_bias #(
    parameter int MAX_COLS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  mvmb_pkg::item_t            item,
    input  logic                       cfg_we,
    input  logic [mvmb_pkg::CNT_W-1:0] cfg_data,
    output logic                       done,
    output mvmb_pkg::result_t          result
);

    mvmb_pkg::cmd_t cmd;

    mvmb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .busy  (busy),
        .cmd   (cmd)
    );

    mvmb_dp #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    // A result appears only after the emit step, and the block is then free again
    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(cmd.emit) && !busy))
        else $error("done without preceding emit step");

    // A bias transfer always produces a result after the bias-add and emit steps
    a_bias_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == mvmb_pkg::OP_BIAS) |-> ##3 done)
        else $error("bias transfer did not produce a result");

    // Multiply, accumulate, emit and capture steps never overlap
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_en, cmd.acc_en, cmd.emit, cmd.capture}))
        else $error("overlapping datapath commands");

endmodule
